/* src/imm_pkg.sv */
`default_nettype none

package imm_pkg;

  localparam int unsigned MaxDim = 8;
  localparam int unsigned DimW   = 4;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned Depth  = 64;
  localparam int unsigned DataW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_MULT   = 2'd2;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_MULT   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [DimW-1:0] a_rows;
    logic [DimW-1:0] a_cols;
    logic [DimW-1:0] b_rows;
    logic [DimW-1:0] b_cols;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic [DataW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [DataW-1:0] product;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic             last;
    logic             mismatch;
  } res_t;

  function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] d);
    logic [DimW-1:0] lim;
    lim = DimW'(MaxDim);
    return (d > lim) ? lim : d;
  endfunction

endpackage

`default_nettype wire

/* src/imm_front.sv */
`default_nettype none

module imm_front import imm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [DimW-1:0]     cfg_wdata_i,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic [1:0]          action_i,
  input  wire logic [IdxW-1:0]     elem_row_i,
  input  wire logic [IdxW-1:0]     elem_col_i,
  input  wire logic signed [DataW-1:0] elem_value_i,
  input  wire logic                q_full_i,
  output logic                     q_push_o,
  output cmd_t                     q_cmd_o,
  output cfg_t                     cfg_o
);

  cfg_t            cfg_q;
  logic [DimW-1:0] nr, nc;
  logic            in_shape;
  logic            keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_A_ROWS: cfg_q.a_rows <= cfg_wdata_i;
        REG_A_COLS: cfg_q.a_cols <= cfg_wdata_i;
        REG_B_ROWS: cfg_q.b_rows <= cfg_wdata_i;
        REG_B_COLS: cfg_q.b_cols <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign nr       = sat_dim((action_i == ACT_LOAD_A) ? cfg_q.a_rows : cfg_q.b_rows);
  assign nc       = sat_dim((action_i == ACT_LOAD_A) ? cfg_q.a_cols : cfg_q.b_cols);
  assign in_shape = ({1'b0, elem_row_i} < nr) && ({1'b0, elem_col_i} < nc);

  always_comb begin
    keep          = 1'b0;
    q_cmd_o.kind  = CMD_MULT;
    q_cmd_o.row   = elem_row_i;
    q_cmd_o.col   = elem_col_i;
    q_cmd_o.value = elem_value_i;
    case (action_i)
      ACT_LOAD_A: begin
        keep         = in_shape;
        q_cmd_o.kind = CMD_LOAD_A;
      end
      ACT_LOAD_B: begin
        keep         = in_shape;
        q_cmd_o.kind = CMD_LOAD_B;
      end
      ACT_MULT: begin
        keep         = 1'b1;
        q_cmd_o.kind = CMD_MULT;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i && keep;
  assign cfg_o    = cfg_q;

endmodule

`default_nettype wire

/* src/imm_cmd_queue.sv */
`default_nettype none

module imm_cmd_queue import imm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      cmd_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* src/imm_res_queue.sv */
`default_nettype none

module imm_res_queue import imm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  res_t      res_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output res_t      res_o
);

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign res_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* src/imm_mac.sv */
`default_nettype none

module imm_mac import imm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic cmd_empty_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  wire logic res_full_i,
  output logic      res_push_o,
  output res_t      res_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WAIT  = 5'b00010,
    ST_ISSUE = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_PUSH  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [IdxW-1:0] r_q, r_d, c_q, c_d, n_q, n_d;
  logic            mis_q, mis_d;

  logic [DataW-1:0] a_mem_q [Depth];
  logic [DataW-1:0] b_mem_q [Depth];
  logic [Depth-1:0] a_vld_q, b_vld_q;
  logic             a_we, b_we;
  logic [AddrW-1:0] wr_addr, a_raddr, b_raddr;

  logic             issue, acc_clr;
  logic             s1_q, s1_last_q, s2_q, s2_last_q, s3_q, s3_last_q;
  logic [DataW-1:0] a_rd_q, b_rd_q;
  logic             a_ok_q, b_ok_q;
  logic [DataW-1:0] a_op, b_op;
  logic [DataW-1:0] pll_d, pll_q;
  logic [HalfW-1:0] plh_d, plh_q, phl_d, phl_q, cross_sum;
  logic [DataW-1:0] prod_q, acc_q;

  logic [DimW-1:0]  nr, nc, ni;
  logic             row_last, col_last, n_last, elem_last, mis;
  logic [IdxW-1:0]  adv_r, adv_c;
  state_e           adv_st;

  assign nr        = sat_dim(cfg_i.a_rows);
  assign nc        = sat_dim(cfg_i.b_cols);
  assign ni        = sat_dim(cfg_i.a_cols);
  assign row_last  = (({1'b0, r_q} + 1'b1) == nr);
  assign col_last  = (({1'b0, c_q} + 1'b1) == nc);
  assign n_last    = (({1'b0, n_q} + 1'b1) == ni);
  assign elem_last = row_last && col_last;
  assign mis       = (cfg_i.a_cols != cfg_i.b_rows) || (cfg_i.a_rows == '0) ||
                     (cfg_i.b_cols == '0);

  // walk row by row, column by column
  always_comb begin
    adv_r  = r_q;
    adv_c  = c_q + 1'b1;
    adv_st = ST_WAIT;
    if (elem_last) begin
      adv_st = ST_IDLE;
    end else if (col_last) begin
      adv_c = '0;
      adv_r = r_q + 1'b1;
    end
  end

  assign wr_addr = {cmd_i.row, cmd_i.col};
  assign a_raddr = {r_q, n_q};
  assign b_raddr = {n_q, c_q};

  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    n_d        = n_q;
    mis_d      = mis_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    a_we       = 1'b0;
    b_we       = 1'b0;
    issue      = 1'b0;
    acc_clr    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_LOAD_A: a_we = 1'b1;
            CMD_LOAD_B: b_we = 1'b1;
            CMD_MULT: begin
              state_d = ST_WAIT;
              r_d     = '0;
              c_d     = '0;
              mis_d   = mis;
            end
            default: ;
          endcase
        end
      end
      ST_WAIT: begin
        if (!res_full_i) begin
          if (mis_q) begin
            res_push_o     = 1'b1;
            res_o.last     = 1'b1;
            res_o.mismatch = 1'b1;
            state_d        = ST_IDLE;
          end else if (ni == '0) begin
            res_push_o = 1'b1;
            res_o.row  = r_q;
            res_o.col  = c_q;
            res_o.last = elem_last;
            r_d        = adv_r;
            c_d        = adv_c;
            state_d    = adv_st;
          end else begin
            acc_clr = 1'b1;
            n_d     = '0;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        issue = 1'b1;
        n_d   = n_q + 1'b1;
        if (n_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (s3_q && s3_last_q) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        res_push_o    = 1'b1;
        res_o.product = acc_q;
        res_o.row     = r_q;
        res_o.col     = c_q;
        res_o.last    = elem_last;
        r_d           = adv_r;
        c_d           = adv_c;
        state_d       = adv_st;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      r_q       <= '0;
      c_q       <= '0;
      n_q       <= '0;
      mis_q     <= 1'b0;
      a_vld_q   <= '0;
      b_vld_q   <= '0;
      s1_q      <= 1'b0;
      s1_last_q <= 1'b0;
      s2_q      <= 1'b0;
      s2_last_q <= 1'b0;
      s3_q      <= 1'b0;
      s3_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      r_q       <= r_d;
      c_q       <= c_d;
      n_q       <= n_d;
      mis_q     <= mis_d;
      if (a_we) a_vld_q[wr_addr] <= 1'b1;
      if (b_we) b_vld_q[wr_addr] <= 1'b1;
      s1_q      <= issue;
      s1_last_q <= issue && n_last;
      s2_q      <= s1_q;
      s2_last_q <= s1_last_q;
      s3_q      <= s2_q;
      s3_last_q <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) a_mem_q[wr_addr] <= cmd_i.value;
    if (b_we) b_mem_q[wr_addr] <= cmd_i.value;
    a_rd_q <= a_mem_q[a_raddr];
    b_rd_q <= b_mem_q[b_raddr];
    a_ok_q <= a_vld_q[a_raddr];
    b_ok_q <= b_vld_q[b_raddr];
  end

  // low 64 bits of a 64x64 product from three 32x32 partial products
  assign a_op      = a_ok_q ? a_rd_q : '0;
  assign b_op      = b_ok_q ? b_rd_q : '0;
  assign pll_d     = a_op[HalfW-1:0] * b_op[HalfW-1:0];
  assign plh_d     = a_op[HalfW-1:0] * b_op[DataW-1:HalfW];
  assign phl_d     = a_op[DataW-1:HalfW] * b_op[HalfW-1:0];
  assign cross_sum = plh_q + phl_q;

  always_ff @(posedge clk_i) begin
    pll_q  <= pll_d;
    plh_q  <= plh_d;
    phl_q  <= phl_d;
    prod_q <= pll_q + {cross_sum, {HalfW{1'b0}}};
    if (acc_clr) acc_q <= '0;
    else if (s3_q) acc_q <= acc_q + prod_q;
  end

endmodule

`default_nettype wire

/* src/int_matrix_multiply.sv */
// Integer matrix multiplier, A (a_rows x a_cols) times B (b_rows x b_cols).
// Configuration: cfg_we_i writes cfg_wdata_i into shape register cfg_idx_i
// (0 a_rows, 1 a_cols, 2 b_rows, 3 b_cols); write only while the block is idle.
// Input: an item is taken on a clock edge with push high and full low.
// action 0/1 stores elem_value_i into A/B at (elem_row_i, elem_col_i); loads
// outside the shape are dropped. action 2 multiplies; action 3 is dropped.
// Output: while empty is low the oldest result sits on the result ports and
// leaves on an edge with pop high. A multiply gives its elements row by row,
// last high on the final one, or a single mismatch beat if a_cols != b_rows
// or a_rows or b_cols is zero. Timing: a four-entry command queue decouples
// intake from the multiply-accumulate engine. A multiply computes its elements
// one at a time on the single shared 64-bit MAC with its read, partial product,
// sum stages; the engine takes no new command until the multiply is done.
// Results wait in a four-entry queue; when the receiver stalls, the engine
// holds before each element until a slot frees, and intake stalls once the
// command queue fills. Reset clears shapes, both queues and store valid bits.
`default_nettype none

module int_matrix_multiply import imm_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_idx_i,
  input  wire logic [DimW-1:0]         cfg_wdata_i,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [1:0]              action_i,
  input  wire logic [IdxW-1:0]         elem_row_i,
  input  wire logic [IdxW-1:0]         elem_col_i,
  input  wire logic signed [DataW-1:0] elem_value_i,
  output logic                         empty,
  input  wire logic                    pop,
  output logic signed [DataW-1:0]      product_o,
  output logic [IdxW-1:0]              out_row_o,
  output logic [IdxW-1:0]              out_col_o,
  output logic                         last_o,
  output logic                         mismatch_o
);

  cfg_t cfg;
  cmd_t fq_cmd, bq_cmd;
  res_t mac_res, head_res;
  logic q_full, q_push, q_empty, q_pop;
  logic r_full, r_push;

  imm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push),
    .full_o       (full),
    .action_i     (action_i),
    .elem_row_i   (elem_row_i),
    .elem_col_i   (elem_col_i),
    .elem_value_i (elem_value_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (fq_cmd),
    .cfg_o        (cfg)
  );

  imm_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (fq_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (bq_cmd)
  );

  imm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_empty_i (q_empty),
    .cmd_i       (bq_cmd),
    .cmd_pop_o   (q_pop),
    .res_full_i  (r_full),
    .res_push_o  (r_push),
    .res_o       (mac_res)
  );

  imm_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_push),
    .res_i   (mac_res),
    .full_o  (r_full),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (head_res)
  );

  assign product_o  = head_res.product;
  assign out_row_o  = head_res.row;
  assign out_col_o  = head_res.col;
  assign last_o     = head_res.last;
  assign mismatch_o = head_res.mismatch;

endmodule

`default_nettype wire

/* src/imm_checker.sv */
`default_nettype none

module imm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [63:0] product_o,
  input wire logic [2:0]  out_row_o,
  input wire logic [2:0]  out_col_o,
  input wire logic        last_o,
  input wire logic        mismatch_o
);

  a_mis_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && mismatch_o) |-> last_o)
    else $error("mismatch beat without last");

  a_mis_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && mismatch_o) |-> (product_o == '0 && out_row_o == '0 && out_col_o == '0))
    else $error("mismatch beat carries nonzero payload");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(product_o) && $stable(out_row_o) &&
                          $stable(out_col_o) && $stable(last_o)))
    else $error("stalled result beat changed");

endmodule

bind int_matrix_multiply imm_checker u_imm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .product_o  (product_o),
  .out_row_o  (out_row_o),
  .out_col_o  (out_col_o),
  .last_o     (last_o),
  .mismatch_o (mismatch_o)
);

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import imm_pkg::*;

  localparam logic [1:0]       ACT_NONE   = 2'd3;
  localparam logic [DataW-1:0] S64_MIN    = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] S64_MAX    = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] ALL_ONES   = '1;
  localparam int unsigned      BEAT_GOAL  = 450;
  localparam int unsigned      SETTLE     = 24;
  localparam int unsigned      HOLD_OFF   = 400;
  localparam int unsigned      QUIET_MAX  = 4000;
  localparam int unsigned      PRINT_MAX  = 50;
  localparam res_t             SHAPE_FAIL = '{product: '0, row: '0, col: '0,
                                              last: 1'b1, mismatch: 1'b1};

  typedef struct packed {
    logic             is_cfg;
    logic [1:0]       sel;
    logic [DimW-1:0]  dim;
    logic [IdxW-1:0]  r;
    logic [IdxW-1:0]  c;
    logic [DataW-1:0] v;
    logic             typed;
    res_t             want;
  } plan_step_t;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_we_i     = 1'b0;
  logic [1:0]              cfg_idx_i    = '0;
  logic [DimW-1:0]         cfg_wdata_i  = '0;
  logic                    push         = 1'b0;
  logic                    full;
  logic [1:0]              action_i     = '0;
  logic [IdxW-1:0]         elem_row_i   = '0;
  logic [IdxW-1:0]         elem_col_i   = '0;
  logic signed [DataW-1:0] elem_value_i = '0;
  logic                    empty;
  logic                    pop          = 1'b0;
  logic signed [DataW-1:0] product_o;
  logic [IdxW-1:0]         out_row_o;
  logic [IdxW-1:0]         out_col_o;
  logic                    last_o;
  logic                    mismatch_o;

  logic [DimW-1:0]  shape_reg [4];
  logic [DataW-1:0] store_a [Depth];
  logic [DataW-1:0] store_b [Depth];
  res_t             product_q [$];
  plan_step_t       plan [$];

  int unsigned errors     = 0;
  int unsigned beats_sent = 0;
  int unsigned hold_left  = 0;
  bit          idle_on    = 1'b1;
  bit          dirty      = 1'b0;

  int_matrix_multiply dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic int unsigned fit_dim(logic [DimW-1:0] d);
    return (d > MaxDim) ? MaxDim : int'(d);
  endfunction

  function automatic res_t solo(logic [DataW-1:0] p);
    return '{product: p, row: '0, col: '0, last: 1'b1, mismatch: 1'b0};
  endfunction

  function automatic plan_step_t shape_step(logic [1:0] idx, logic [DimW-1:0] d);
    plan_step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.sel    = idx;
    s.dim    = d;
    return s;
  endfunction

  function automatic plan_step_t beat_step(logic [1:0] act, logic [IdxW-1:0] r,
                                           logic [IdxW-1:0] c, logic [DataW-1:0] v);
    plan_step_t s;
    s = '0;
    s.sel = act;
    s.r   = r;
    s.c   = c;
    s.v   = v;
    return s;
  endfunction

  function automatic plan_step_t known_step(res_t want);
    plan_step_t s;
    s = beat_step(ACT_MULT, '0, '0, '0);
    s.typed = 1'b1;
    s.want  = want;
    return s;
  endfunction

  function automatic logic [DataW-1:0] rand_value();
    int small_v;
    small_v = int'($urandom_range(16)) - 8;
    case ($urandom_range(7))
      0: return S64_MIN;
      1: return S64_MAX;
      2: return DataW'(small_v);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int unsigned pick_dim();
    return ($urandom_range(19) == 0) ? MaxDim : $urandom_range(1, 3);
  endfunction

  // Loads fill the model stores; a multiply queues its expected result beats.
  task automatic predict_beat(plan_step_t s);
    int unsigned nr, nc, ni;
    logic [DataW-1:0] acc;
    case (s.sel)
      ACT_LOAD_A: begin
        if (s.r < fit_dim(shape_reg[REG_A_ROWS]) && s.c < fit_dim(shape_reg[REG_A_COLS]))
          store_a[s.r * MaxDim + s.c] = s.v;
      end
      ACT_LOAD_B: begin
        if (s.r < fit_dim(shape_reg[REG_B_ROWS]) && s.c < fit_dim(shape_reg[REG_B_COLS]))
          store_b[s.r * MaxDim + s.c] = s.v;
      end
      ACT_MULT: begin
        if (shape_reg[REG_A_COLS] != shape_reg[REG_B_ROWS] ||
            shape_reg[REG_A_ROWS] == 0 || shape_reg[REG_B_COLS] == 0) begin
          product_q.push_back(SHAPE_FAIL);
        end else begin
          nr = fit_dim(shape_reg[REG_A_ROWS]);
          nc = fit_dim(shape_reg[REG_B_COLS]);
          ni = fit_dim(shape_reg[REG_A_COLS]);
          for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
              acc = '0;
              for (int n = 0; n < ni; n++)
                acc = acc + store_a[r * MaxDim + n] * store_b[n * MaxDim + c];
              product_q.push_back('{product: acc, row: IdxW'(r), col: IdxW'(c),
                                    last: (r + 1 == nr && c + 1 == nc), mismatch: 1'b0});
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic log_mismatch(string what);
    if (errors < PRINT_MAX) $display("%0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic check_beat();
    res_t want;
    if (product_q.size() == 0) begin
      log_mismatch($sformatf("unexpected beat product %h (%0d,%0d)",
                             product_o, out_row_o, out_col_o));
      return;
    end
    want = product_q.pop_front();
    if (product_o !== want.product)
      log_mismatch($sformatf("product %h, expected %h at (%0d,%0d)",
                             product_o, want.product, want.row, want.col));
    if (out_row_o !== want.row)
      log_mismatch($sformatf("out_row %0d, expected %0d", out_row_o, want.row));
    if (out_col_o !== want.col)
      log_mismatch($sformatf("out_col %0d, expected %0d", out_col_o, want.col));
    if (last_o !== want.last)
      log_mismatch($sformatf("last %b, expected %b at (%0d,%0d)",
                             last_o, want.last, want.row, want.col));
    if (mismatch_o !== want.mismatch)
      log_mismatch($sformatf("mismatch %b, expected %b", mismatch_o, want.mismatch));
  endtask

  task automatic send_beat(plan_step_t s);
    while (idle_on && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    action_i     <= s.sel;
    elem_row_i   <= s.r;
    elem_col_i   <= s.c;
    elem_value_i <= s.v;
    do @(posedge clk_i); while (full);
    if (s.typed) product_q.push_back(s.want);
    else predict_beat(s);
    if (s.sel != ACT_NONE) beats_sent++;
    dirty = 1'b1;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (product_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    dirty = 1'b0;
  endtask

  task automatic set_shape(logic [1:0] idx, logic [DimW-1:0] d);
    if (dirty) drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    shape_reg[idx] = d;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_step(plan_step_t s);
    if (s.is_cfg) set_shape(s.sel, s.dim);
    else send_beat(s);
  endtask

  // Receiver: random pop gaps, plus a counted hold-off on request.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_beat();
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= !(idle_on && $urandom_range(99) < 26);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned pn, nr, nk, kb, nc;
    for (int i = 0; i < 4; i++) shape_reg[i] = '0;
    for (int i = 0; i < Depth; i++) begin
      store_a[i] = '0;
      store_b[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan = '{
      known_step(SHAPE_FAIL),
      shape_step(REG_A_ROWS, 4'd1), shape_step(REG_A_COLS, 4'd1),
      shape_step(REG_B_ROWS, 4'd1), shape_step(REG_B_COLS, 4'd1),
      beat_step(ACT_LOAD_A, 3'd0, 3'd0, S64_MIN),
      beat_step(ACT_LOAD_B, 3'd0, 3'd0, ALL_ONES),
      known_step(solo(S64_MIN)),
      beat_step(ACT_LOAD_A, 3'd0, 3'd0, S64_MAX),
      beat_step(ACT_LOAD_B, 3'd0, 3'd0, S64_MAX),
      beat_step(ACT_LOAD_A, 3'd1, 3'd0, 64'd5),
      beat_step(ACT_LOAD_B, 3'd0, 3'd1, 64'd7),
      beat_step(ACT_NONE, 3'd7, 3'd7, ALL_ONES),
      known_step(solo(64'd1)),
      shape_step(REG_A_COLS, 4'd2),
      known_step(SHAPE_FAIL),
      shape_step(REG_B_ROWS, 4'd2), shape_step(REG_B_COLS, 4'd0),
      known_step(SHAPE_FAIL),
      shape_step(REG_A_COLS, 4'd0), shape_step(REG_B_ROWS, 4'd0),
      shape_step(REG_B_COLS, 4'd2),
      beat_step(ACT_MULT, 3'd0, 3'd0, '0),
      shape_step(REG_A_ROWS, 4'd15), shape_step(REG_A_COLS, 4'd9),
      shape_step(REG_B_ROWS, 4'd9), shape_step(REG_B_COLS, 4'd8),
      beat_step(ACT_LOAD_A, 3'd7, 3'd7, 64'd5),
      beat_step(ACT_LOAD_B, 3'd7, 3'd7, -64'sd7),
      beat_step(ACT_LOAD_A, 3'd7, 3'd0, S64_MIN),
      beat_step(ACT_MULT, 3'd7, 3'd7, ALL_ONES),
      shape_step(REG_B_ROWS, 4'd8),
      known_step(SHAPE_FAIL)
    };
    foreach (plan[i]) run_step(plan[i]);

    pn = 0;
    while (beats_sent < BEAT_GOAL) begin
      idle_on = !(pn >= 4 && pn < 8);
      if (pn == 1) begin
        nr = 2; nk = 3; kb = 3; nc = 2;
      end else if ($urandom_range(5) == 0) begin
        nr = $urandom_range(15); nk = $urandom_range(15);
        kb = $urandom_range(15); nc = $urandom_range(15);
      end else begin
        nr = pick_dim();
        nk = ($urandom_range(9) == 0) ? 0 : pick_dim();
        kb = nk;
        nc = pick_dim();
      end
      set_shape(REG_A_ROWS, DimW'(nr));
      set_shape(REG_A_COLS, DimW'(nk));
      set_shape(REG_B_ROWS, DimW'(kb));
      set_shape(REG_B_COLS, DimW'(nc));

      for (int r = 0; r < fit_dim(DimW'(nr)); r++)
        for (int c = 0; c < fit_dim(DimW'(nk)); c++)
          if ($urandom_range(9) != 0)
            send_beat(beat_step(ACT_LOAD_A, IdxW'(r), IdxW'(c), rand_value()));
      for (int r = 0; r < fit_dim(DimW'(kb)); r++)
        for (int c = 0; c < fit_dim(DimW'(nc)); c++)
          if ($urandom_range(9) != 0)
            send_beat(beat_step(ACT_LOAD_B, IdxW'(r), IdxW'(c), rand_value()));

      // Stall the receiver and offer six multiplies so that intake backs up.
      if (pn == 1) begin
        hold_left = HOLD_OFF;
        repeat (6) send_beat(beat_step(ACT_MULT, IdxW'($urandom), IdxW'($urandom),
                                       rand_value()));
      end

      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(3))
          send_beat(beat_step(2'($urandom_range(3)), IdxW'($urandom), IdxW'($urandom),
                              rand_value()));
        send_beat(beat_step(ACT_MULT, IdxW'($urandom), IdxW'($urandom), rand_value()));
      end
      pn++;
    end

    idle_on = 1'b1;
    drain();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
